// ----- rtl/frld_pkg.sv -----
// Shared types, constants and helpers of the raster drawing engine.
`timescale 1ns / 1ps

package frld_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Internal coordinate width, wide enough for a start point plus a line length.
    localparam int COORD_W = 18;
    localparam logic signed [COORD_W-1:0] COORD_FAR = 18'sd65535;

    localparam logic [2:0] OP_FILL_ALL   = 3'd0;
    localparam logic [2:0] OP_SET_PIXEL  = 3'd1;
    localparam logic [2:0] OP_LINE       = 3'd2;
    localparam logic [2:0] OP_TRACE_RECT = 3'd3;
    localparam logic [2:0] OP_FILL_RECT  = 3'd4;
    localparam logic [2:0] OP_READ_PIXEL = 3'd5;

    localparam logic [1:0] DIR_POS_X = 2'd0;
    localparam logic [1:0] DIR_POS_Y = 2'd1;
    localparam logic [1:0] DIR_NEG_X = 2'd2;
    localparam logic [1:0] DIR_NEG_Y = 2'd3;

    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [2:0] REG_COLOR_MODE   = 3'd2;
    localparam logic [2:0] REG_DRAW_RED     = 3'd3;
    localparam logic [2:0] REG_DRAW_GREEN   = 3'd4;
    localparam logic [2:0] REG_DRAW_BLUE    = 3'd5;

    localparam logic [1:0] SEG_LEFT   = 2'd0;
    localparam logic [1:0] SEG_RIGHT  = 2'd1;
    localparam logic [1:0] SEG_TOP    = 2'd2;
    localparam logic [1:0] SEG_BOTTOM = 2'd3;

    localparam logic [6:0] RST_IMAGE_WIDTH  = 7'd64;
    localparam logic [6:0] RST_IMAGE_HEIGHT = 7'd64;
    localparam logic       RST_COLOR_MODE   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_READ,
        ST_RDATA,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [6:0] image_width;
        logic [6:0] image_height;
        logic       color_mode;
        logic [7:0] draw_red;
        logic [7:0] draw_green;
        logic [7:0] draw_blue;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic [1:0]         line_direction;
        logic signed [15:0] line_length;
    } cmd_t;

    typedef struct packed {
        logic [7:0] read_red;
        logic [7:0] read_green;
        logic [7:0] read_blue;
        logic       outside_image;
    } result_t;

    function automatic logic signed [COORD_W-1:0] sext16(input logic [15:0] v);
        return {{(COORD_W-16){v[15]}}, v};
    endfunction

endpackage

// ----- rtl/frld_ram.sv -----
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module frld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/frld_engine.sv -----
// Drawing sequencer: shared clip unit, pixel walker and the three color planes.
`timescale 1ns / 1ps

module frld_engine #(
    parameter int MAX_WIDTH  = frld_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = frld_pkg::DEF_MAX_HEIGHT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  frld_pkg::cmd_t    cmd,
    input  frld_pkg::cfg_t    cfg,
    input  logic              res_ready,
    output logic              ready,
    output logic              res_valid,
    output frld_pkg::result_t res
);

    localparam int CW    = frld_pkg::COORD_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [10:0]   MW       = 11'(MAX_WIDTH);
    localparam logic [10:0]   MH       = 11'(MAX_HEIGHT);
    localparam logic [AW-1:0] ROW_STEP = AW'(MAX_WIDTH);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

    frld_pkg::state_t state_reg, state_next;
    logic [2:0]          op_reg, op_next;
    logic signed [CW-1:0] xa_reg, xa_next, xb_reg, xb_next;
    logic signed [CW-1:0] ya_reg, ya_next, yb_reg, yb_next;
    logic [1:0]          seg_reg, seg_next, last_reg, last_next;
    logic [XW-1:0]       x_reg, x_next, xlo_reg, xlo_next, xhi_reg, xhi_next;
    logic [YW-1:0]       y_reg, y_next, yhi_reg, yhi_next;
    logic [AW-1:0]       clr_reg, clr_next;
    frld_pkg::result_t   res_reg, res_next;

    logic signed [CW-1:0] s_x1, s_y1, s_x2, s_y2, s_len;
    logic signed [CW-1:0] xmin, xmax, ymin, ymax;
    logic signed [CW-1:0] sxa, sxb, sya, syb;
    logic signed [CW-1:0] cxlo, cxhi, cylo, cyhi;
    logic signed [CW-1:0] ewm1, ehm1;
    logic [10:0]          ew, eh;
    logic                 clip_empty;

    logic          we_r, we_gb, re;
    logic [AW-1:0] addr;
    logic [7:0]    wd_r, wd_g, wd_b, q_r, q_g, q_b;

    assign ew   = ({4'b0, cfg.image_width} > MW) ? MW : {4'b0, cfg.image_width};
    assign eh   = ({4'b0, cfg.image_height} > MH) ? MH : {4'b0, cfg.image_height};
    assign ewm1 = $signed({{(CW-11){1'b0}}, ew}) - 18'sd1;
    assign ehm1 = $signed({{(CW-11){1'b0}}, eh}) - 18'sd1;

    assign s_x1  = frld_pkg::sext16(cmd.first_x);
    assign s_y1  = frld_pkg::sext16(cmd.first_y);
    assign s_x2  = frld_pkg::sext16(cmd.second_x);
    assign s_y2  = frld_pkg::sext16(cmd.second_y);
    assign s_len = frld_pkg::sext16(cmd.line_length);
    assign xmin  = (s_x1 > s_x2) ? s_x2 : s_x1;
    assign xmax  = (s_x1 > s_x2) ? s_x1 : s_x2;
    assign ymin  = (s_y1 > s_y2) ? s_y2 : s_y1;
    assign ymax  = (s_y1 > s_y2) ? s_y1 : s_y2;

    // The four sides of a traced outline are walked as separate thin rectangles.
    always_comb
    begin
        sxa = xa_reg;
        sxb = xb_reg;
        sya = ya_reg;
        syb = yb_reg;
        if (op_reg == frld_pkg::OP_TRACE_RECT)
        begin
            unique case (seg_reg)
                frld_pkg::SEG_LEFT:   sxb = xa_reg;
                frld_pkg::SEG_RIGHT:  sxa = xb_reg;
                frld_pkg::SEG_TOP:    syb = ya_reg;
                frld_pkg::SEG_BOTTOM: sya = yb_reg;
                default:              sxb = xa_reg;
            endcase
        end
    end

    assign cxlo       = sxa[CW-1] ? '0 : sxa;
    assign cxhi       = (sxb > ewm1) ? ewm1 : sxb;
    assign cylo       = sya[CW-1] ? '0 : sya;
    assign cyhi       = (syb > ehm1) ? ehm1 : syb;
    assign clip_empty = (cxlo > cxhi) || (cylo > cyhi);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= frld_pkg::ST_CLEAR;
            clr_reg   <= '0;
            seg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            seg_reg   <= seg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        xa_reg   <= xa_next;
        xb_reg   <= xb_next;
        ya_reg   <= ya_next;
        yb_reg   <= yb_next;
        last_reg <= last_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        xlo_reg  <= xlo_next;
        xhi_reg  <= xhi_next;
        yhi_reg  <= yhi_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        xa_next    = xa_reg;
        xb_next    = xb_reg;
        ya_next    = ya_reg;
        yb_next    = yb_reg;
        seg_next   = seg_reg;
        last_next  = last_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        yhi_next   = yhi_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        ready      = 1'b0;
        res_valid  = 1'b0;
        we_r       = 1'b0;
        we_gb      = 1'b0;
        re         = 1'b0;
        addr       = AW'(y_reg) * ROW_STEP + AW'(x_reg);
        wd_r       = cfg.draw_red;
        wd_g       = cfg.draw_green;
        wd_b       = cfg.draw_blue;

        unique case (state_reg)
            frld_pkg::ST_CLEAR:
            begin
                we_r  = 1'b1;
                we_gb = 1'b1;
                addr  = clr_reg;
                wd_r  = '0;
                wd_g  = '0;
                wd_b  = '0;
                if (clr_reg == LAST_ADR)
                begin
                    state_next = frld_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            frld_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    op_next    = cmd.operation;
                    seg_next   = '0;
                    last_next  = '0;
                    res_next   = '0;
                    xa_next    = s_x1;
                    xb_next    = s_x1;
                    ya_next    = s_y1;
                    yb_next    = s_y1;
                    state_next = frld_pkg::ST_SETUP;
                    unique case (cmd.operation)
                        frld_pkg::OP_FILL_ALL:
                        begin
                            xa_next = '0;
                            xb_next = frld_pkg::COORD_FAR;
                            ya_next = '0;
                            yb_next = frld_pkg::COORD_FAR;
                        end
                        frld_pkg::OP_SET_PIXEL, frld_pkg::OP_READ_PIXEL:
                        begin
                        end
                        frld_pkg::OP_LINE:
                        begin
                            unique case (cmd.line_direction)
                                frld_pkg::DIR_POS_X: xb_next = s_x1 + s_len;
                                frld_pkg::DIR_POS_Y: yb_next = s_y1 + s_len;
                                frld_pkg::DIR_NEG_X: xa_next = s_x1 - s_len;
                                frld_pkg::DIR_NEG_Y: ya_next = s_y1 - s_len;
                                default:             xb_next = s_x1 + s_len;
                            endcase
                            if (s_len[CW-1])
                            begin
                                state_next = frld_pkg::ST_DONE;
                            end
                        end
                        frld_pkg::OP_TRACE_RECT, frld_pkg::OP_FILL_RECT:
                        begin
                            xa_next = xmin;
                            xb_next = xmax;
                            ya_next = ymin;
                            yb_next = ymax;
                            if (cmd.operation == frld_pkg::OP_TRACE_RECT)
                            begin
                                last_next = frld_pkg::SEG_BOTTOM;
                            end
                        end
                        default:
                        begin
                            state_next = frld_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            frld_pkg::ST_SETUP:
            begin
                if (clip_empty)
                begin
                    if (op_reg == frld_pkg::OP_READ_PIXEL)
                    begin
                        res_next.outside_image = 1'b1;
                        state_next = frld_pkg::ST_DONE;
                    end
                    else if (seg_reg == last_reg)
                    begin
                        state_next = frld_pkg::ST_DONE;
                    end
                    else
                    begin
                        seg_next = seg_reg + 1'b1;
                    end
                end
                else
                begin
                    x_next   = cxlo[XW-1:0];
                    xlo_next = cxlo[XW-1:0];
                    xhi_next = cxhi[XW-1:0];
                    y_next   = cylo[YW-1:0];
                    yhi_next = cyhi[YW-1:0];
                    if (op_reg == frld_pkg::OP_READ_PIXEL)
                    begin
                        state_next = frld_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = frld_pkg::ST_DRAW;
                    end
                end
            end
            frld_pkg::ST_DRAW:
            begin
                we_r  = 1'b1;
                we_gb = cfg.color_mode;
                if (x_reg == xhi_reg)
                begin
                    x_next = xlo_reg;
                    if (y_reg == yhi_reg)
                    begin
                        if (seg_reg == last_reg)
                        begin
                            state_next = frld_pkg::ST_DONE;
                        end
                        else
                        begin
                            seg_next   = seg_reg + 1'b1;
                            state_next = frld_pkg::ST_SETUP;
                        end
                    end
                    else
                    begin
                        y_next = y_reg + 1'b1;
                    end
                end
                else
                begin
                    x_next = x_reg + 1'b1;
                end
            end
            frld_pkg::ST_READ:
            begin
                re         = 1'b1;
                state_next = frld_pkg::ST_RDATA;
            end
            frld_pkg::ST_RDATA:
            begin
                res_next.read_red   = q_r;
                res_next.read_green = cfg.color_mode ? q_g : 8'd0;
                res_next.read_blue  = cfg.color_mode ? q_b : 8'd0;
                state_next          = frld_pkg::ST_DONE;
            end
            frld_pkg::ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = frld_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = frld_pkg::ST_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    frld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_red (
        .clk   (clk),
        .we    (we_r),
        .re    (re),
        .addr  (addr),
        .wdata (wd_r),
        .rdata (q_r)
    );

    frld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_green (
        .clk   (clk),
        .we    (we_gb),
        .re    (re),
        .addr  (addr),
        .wdata (wd_g),
        .rdata (q_g)
    );

    frld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram_blue (
        .clk   (clk),
        .we    (we_gb),
        .re    (re),
        .addr  (addr),
        .wdata (wd_b),
        .rdata (q_b)
    );

endmodule

// ----- rtl/framebuffer_rect_line_draw.sv -----
// Top level of the raster drawing engine: register file, command intake and result register.
// After reset the framebuffer is cleared one pixel per cycle, all MAX_WIDTH*MAX_HEIGHT of them,
// before the first command word is taken; reset also restores the configuration defaults.
// A command runs S clip setups (4 for an outline, none for a negative-length line or an unused
// code, else 1) and writes P pixels one a cycle. A pixel read inside the image runs setup, RAM
// read and data capture; outside, setup sets outside_image. The next command is taken once
// the result has moved to the output register; configuration writes are taken at any time.
`timescale 1ns / 1ps

module framebuffer_rect_line_draw #(
    parameter int MAX_WIDTH  = frld_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = frld_pkg::DEF_MAX_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // first_x, first_y, second_x, second_y, line_direction, line_length, zero fill.
    input  logic [87:0] s_axis_tdata,
    // operation.
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // read_red, read_green, read_blue.
    output logic [23:0] m_axis_tdata,
    // outside_image.
    output logic [0:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    frld_pkg::cfg_t    cfg_reg;
    frld_pkg::cmd_t    cmd;
    frld_pkg::result_t eng_res, out_reg;
    logic              out_valid_reg;
    logic              eng_ready, eng_valid, take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width  <= frld_pkg::RST_IMAGE_WIDTH;
            cfg_reg.image_height <= frld_pkg::RST_IMAGE_HEIGHT;
            cfg_reg.color_mode   <= frld_pkg::RST_COLOR_MODE;
            cfg_reg.draw_red     <= '0;
            cfg_reg.draw_green   <= '0;
            cfg_reg.draw_blue    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                frld_pkg::REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data[6:0];
                frld_pkg::REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data[6:0];
                frld_pkg::REG_COLOR_MODE:   cfg_reg.color_mode   <= cfg_data[0];
                frld_pkg::REG_DRAW_RED:     cfg_reg.draw_red     <= cfg_data;
                frld_pkg::REG_DRAW_GREEN:   cfg_reg.draw_green   <= cfg_data;
                frld_pkg::REG_DRAW_BLUE:    cfg_reg.draw_blue    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cmd.operation      = s_axis_tuser;
    assign cmd.first_x        = s_axis_tdata[15:0];
    assign cmd.first_y        = s_axis_tdata[31:16];
    assign cmd.second_x       = s_axis_tdata[47:32];
    assign cmd.second_y       = s_axis_tdata[63:48];
    assign cmd.line_direction = s_axis_tdata[65:64];
    assign cmd.line_length    = s_axis_tdata[81:66];

    assign s_axis_tready = eng_ready;
    assign take          = !out_valid_reg || m_axis_tready;

    frld_engine #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_axis_tvalid && eng_ready),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .res_ready (take),
        .ready     (eng_ready),
        .res_valid (eng_valid),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_valid && take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && take)
        begin
            out_reg <= eng_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.read_blue, out_reg.read_green, out_reg.read_red};
    assign m_axis_tuser  = out_reg.outside_image;

endmodule
